>>> rtl/mpool_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpool_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_IN_W    = 64;
  localparam int MAX_KERNEL  = 4;
  localparam int MAX_OUT_W   = 32;
  localparam int MAX_IN_H    = 64;
  localparam int MAX_OUT_H   = 32;
  localparam int MAX_CHAN    = 256;
  localparam int RESULT_CAP  = 64;
  localparam int COL_W       = $clog2(MAX_IN_W);
  localparam int KSEL_W      = $clog2(MAX_KERNEL);
  localparam int ADDR_W      = KSEL_W + COL_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAD       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd7;

  // Clamped geometry seen by the datapath
  typedef struct packed {
    logic [6:0] iw;
    logic [6:0] ih;
    logic [5:0] ow;
    logic [5:0] oh;
    logic [2:0] k;
    logic [2:0] s;
    logic [1:0] p;
    logic [8:0] ch;
  } cfg_t;

  // Row-end request from front to back
  typedef struct packed {
    logic [5:0] r;
    logic       pd;
    logic       lp;
  } cmd_t;

  // Line store write request
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } wr_t;

endpackage
`default_nettype wire

>>> rtl/mpool_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module mpool_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mpool_pkg::cmd_t  din,
  input  wire logic             pop,
  output mpool_pkg::cmd_t       dout,
  output logic                  empty,
  output logic                  full
);

  mpool_pkg::cmd_t mem_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign dout  = mem_r[rp_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= din;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/mpool_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mpool_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mpool_pkg::cfg_t                cfg,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [mpool_pkg::SAMPLE_W-1:0] in_tdata,
  input  wire logic                           q_empty,
  input  wire logic                           back_idle,
  output mpool_pkg::wr_t                      wr,
  output logic                                push,
  output mpool_pkg::cmd_t                     cmd
);

  logic [5:0] col_r, row_r;
  logic [7:0] plane_r;
  logic       acc, row_done, plane_done, last_plane;

  // Take a sample only when nothing still reads the line store
  assign in_tready = q_empty && back_idle;
  assign acc       = in_tvalid && in_tready;

  assign row_done   = ({1'b0, col_r} + 7'd1) >= cfg.iw;
  assign plane_done = row_done && (({1'b0, row_r} + 7'd1) >= cfg.ih);
  assign last_plane = ({1'b0, plane_r} + 9'd1) >= cfg.ch;

  // Write the sample into its row slot
  assign wr.en   = acc;
  assign wr.addr = {row_r[mpool_pkg::KSEL_W-1:0], col_r};
  assign wr.data = in_tdata;

  // Request window output at each row end
  assign push   = acc && row_done;
  assign cmd.r  = row_r;
  assign cmd.pd = plane_done;
  assign cmd.lp = last_plane;

  // Advance raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else if (acc) begin
      if (!row_done) begin
        col_r <= col_r + 6'd1;
      end else begin
        col_r <= '0;
        if (!plane_done) begin
          row_r <= row_r + 6'd1;
        end else begin
          row_r   <= '0;
          plane_r <= last_plane ? 8'd0 : plane_r + 8'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/mpool_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mpool_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mpool_pkg::cfg_t                 cfg,
  input  wire mpool_pkg::wr_t                  wr,
  input  wire logic                            cmd_valid,
  input  wire mpool_pkg::cmd_t                 cmd,
  output logic                                 cmd_pop,
  output logic                                 idle,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mpool_pkg::SAMPLE_W-1:0]       out_tdata,
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_WIN  = 3'd2;
  localparam logic [2:0] S_DRN  = 3'd3;
  localparam logic [2:0] S_EMT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [mpool_pkg::SAMPLE_W-1:0] store [0:(1 << mpool_pkg::ADDR_W)-1];

  logic [2:0] state_r;
  mpool_pkg::cmd_t cur_r;
  logic [5:0] orow_r;
  logic [4:0] ox_r;
  logic [6:0] n_r;
  logic [1:0] dy_r, dx_r;
  logic signed [9:0] fy_r;

  logic                                  rd_v_r, first_r, ins_r;
  logic [mpool_pkg::SAMPLE_W-1:0]        mem_q_r;
  logic signed [mpool_pkg::SAMPLE_W-1:0] best_r, v;

  logic                                  pend_v_r, pend_pe_r, pend_le_r;
  logic [mpool_pkg::SAMPLE_W-1:0]        pend_val_r;

  logic                                  out_v_r, out_last_r;
  logic [1:0]                            out_user_r;
  logic [mpool_pkg::SAMPLE_W-1:0]        out_data_r;

  logic [8:0] prod_y;
  logic [7:0] prod_x;
  logic signed [9:0] fy, endy, fx, y, x;
  logic row_go, in_plane, win_last, col_last, can_push, push;
  logic [mpool_pkg::ADDR_W-1:0] rd_addr;
  logic [1:0]                    push_user;
  logic                          push_last;
  logic [mpool_pkg::SAMPLE_W-1:0] push_data;
  logic pe_new;
  logic force_end;

  assign idle    = (state_r == S_IDLE);
  assign cmd_pop = idle && cmd_valid;

  // Window origin for the current output row and column
  assign prod_y = orow_r * cfg.s;
  assign prod_x = ox_r * cfg.s;
  assign fy     = $signed({1'b0, prod_y}) - $signed({8'd0, cfg.p});
  assign endy   = fy + $signed({7'd0, cfg.k}) - 10'sd1;
  assign row_go = (orow_r < cfg.oh)
               && (({1'b0, n_r} + {2'd0, cfg.ow}) <= 8'(mpool_pkg::RESULT_CAP))
               && (cur_r.pd || (endy <= $signed({4'd0, cur_r.r})));

  assign fx = $signed({2'd0, prod_x}) - $signed({8'd0, cfg.p});
  assign y  = fy_r + $signed({8'd0, dy_r});
  assign x  = fx + $signed({8'd0, dx_r});
  assign in_plane = !y[9] && !x[9] && (y < $signed({3'd0, cfg.ih}))
                 && (x < $signed({3'd0, cfg.iw}));
  assign rd_addr  = {y[mpool_pkg::KSEL_W-1:0], x[mpool_pkg::COL_W-1:0]};
  assign win_last = ({1'b0, dy_r} == cfg.k - 3'd1) && ({1'b0, dx_r} == cfg.k - 3'd1);
  assign col_last = ({1'b0, ox_r} + 6'd1) == cfg.ow;
  assign pe_new   = (({1'b0, orow_r} + 7'd1) >= {1'b0, cfg.oh}) && col_last;
  assign force_end = cur_r.pd && (orow_r < cfg.oh);

  assign can_push = !out_v_r || out_tready;
  assign v = ins_r ? $signed(mem_q_r) : '0;

  // Decide what leaves the pending slot
  always_comb begin
    push      = 1'b0;
    push_data = pend_val_r;
    push_user = {pend_le_r, pend_pe_r};
    push_last = 1'b0;
    if (state_r == S_EMT && pend_v_r && can_push) begin
      push = 1'b1;
    end else if (state_r == S_FIN && pend_v_r && can_push) begin
      push      = 1'b1;
      push_last = 1'b1;
      if (force_end) push_user = {cur_r.lp, 1'b1};
    end
  end

  // Line store: one write and one registered read
  always_ff @(posedge clk) begin
    if (wr.en) store[wr.addr] <= wr.data;
    mem_q_r <= store[rd_addr];
  end

  // Fold each read into the running maximum
  always_ff @(posedge clk) begin
    if (rd_v_r && (first_r || v > best_r)) best_r <= v;
  end

  // Sequence rows, windows and taps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      orow_r   <= '0;
      n_r      <= '0;
      ox_r     <= '0;
      dy_r     <= '0;
      dx_r     <= '0;
      rd_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      rd_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_r   <= cmd;
            n_r     <= '0;
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          if (row_go) begin
            fy_r    <= fy;
            ox_r    <= '0;
            dy_r    <= '0;
            dx_r    <= '0;
            state_r <= S_WIN;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_WIN: begin
          rd_v_r  <= 1'b1;
          first_r <= (dy_r == 2'd0) && (dx_r == 2'd0);
          ins_r   <= in_plane;
          if (win_last) begin
            state_r <= S_DRN;
          end else if ({1'b0, dx_r} == cfg.k - 3'd1) begin
            dx_r <= '0;
            dy_r <= dy_r + 2'd1;
          end else begin
            dx_r <= dx_r + 2'd1;
          end
        end
        S_DRN: state_r <= S_EMT;
        S_EMT: begin
          if (!pend_v_r || can_push) begin
            pend_v_r   <= 1'b1;
            pend_val_r <= best_r;
            pend_pe_r  <= pe_new;
            pend_le_r  <= pe_new && cur_r.lp;
            dy_r       <= '0;
            dx_r       <= '0;
            if (col_last) begin
              orow_r  <= orow_r + 6'd1;
              n_r     <= n_r + {1'b0, cfg.ow};
              state_r <= S_ROW;
            end else begin
              ox_r    <= ox_r + 5'd1;
              state_r <= S_WIN;
            end
          end
        end
        S_FIN: begin
          if (!pend_v_r || can_push) begin
            pend_v_r <= 1'b0;
            if (cur_r.pd) orow_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_data;
      out_user_r <= push_user;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 7'(mpool_pkg::RESULT_CAP))
    else $error("result count beyond cap");
  a_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW && row_go) |-> (orow_r < cfg.oh))
    else $error("row started past output height");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_IDLE))
    else $error("line store written while windows read");
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> ($past(state_r) == S_WIN))
    else $error("tap data without a read");
`endif

endmodule
`default_nettype wire

>>> rtl/max_pool_2d_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A result waits in a pending slot until the next window is done or the request finishes.
// Throughput: one tap per cycle while a window is read, but a result held by output
// back-pressure stops the windows; input is not taken while any row-end request is
// still queued or being worked off.
// Reset: sync active-low rst_n clears counters, queue, output valid; line store kept.
module max_pool_2d_stream_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] max_value
  output logic [1:0]       out_tuser,  // [0] plane_end, [1] layer_end
  output logic             out_tlast,  // run_end
  input  wire logic        cfg_we,
  input  wire logic [mpool_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mpool_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [6:0] iw_r, ih_r;
  logic [5:0] ow_r, oh_r;
  logic [2:0] k_r, s_r;
  logic [1:0] p_r;
  logic [8:0] ch_r;
  mpool_pkg::cfg_t cfg;
  mpool_pkg::wr_t  wr;
  mpool_pkg::cmd_t cmd_in, cmd_out;
  logic push, pop, q_empty, q_full, back_idle;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= 7'd8; ih_r <= 7'd8; ow_r <= 6'd4; oh_r <= 6'd4;
      k_r  <= 3'd2; s_r  <= 3'd2; p_r  <= 2'd0; ch_r <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpool_pkg::REG_IN_WIDTH:   iw_r <= cfg_wdata[6:0];
        mpool_pkg::REG_IN_HEIGHT:  ih_r <= cfg_wdata[6:0];
        mpool_pkg::REG_OUT_WIDTH:  ow_r <= cfg_wdata[5:0];
        mpool_pkg::REG_OUT_HEIGHT: oh_r <= cfg_wdata[5:0];
        mpool_pkg::REG_KERNEL:     k_r  <= cfg_wdata[2:0];
        mpool_pkg::REG_STRIDE:     s_r  <= cfg_wdata[2:0];
        mpool_pkg::REG_PAD:        p_r  <= cfg_wdata[1:0];
        mpool_pkg::REG_CHANNELS:   ch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp registers to the supported geometry (stride only raised from zero, pad passed as is)
  always_comb begin
    cfg.iw = (iw_r == '0) ? 7'd1 : (iw_r > 7'(mpool_pkg::MAX_IN_W)) ? 7'(mpool_pkg::MAX_IN_W) : iw_r;
    cfg.ih = (ih_r == '0) ? 7'd1 : (ih_r > 7'(mpool_pkg::MAX_IN_H)) ? 7'(mpool_pkg::MAX_IN_H) : ih_r;
    cfg.ow = (ow_r == '0) ? 6'd1 : (ow_r > 6'(mpool_pkg::MAX_OUT_W)) ? 6'(mpool_pkg::MAX_OUT_W) : ow_r;
    cfg.oh = (oh_r == '0) ? 6'd1 : (oh_r > 6'(mpool_pkg::MAX_OUT_H)) ? 6'(mpool_pkg::MAX_OUT_H) : oh_r;
    cfg.k  = (k_r == '0) ? 3'd1 : (k_r > 3'(mpool_pkg::MAX_KERNEL)) ? 3'(mpool_pkg::MAX_KERNEL) : k_r;
    cfg.s  = (s_r == '0) ? 3'd1 : s_r;
    cfg.p  = p_r;
    cfg.ch = (ch_r == '0) ? 9'd1 : (ch_r > 9'(mpool_pkg::MAX_CHAN)) ? 9'(mpool_pkg::MAX_CHAN) : ch_r;
  end

  mpool_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_empty   (q_empty),
    .back_idle (back_idle),
    .wr        (wr),
    .push      (push),
    .cmd       (cmd_in)
  );

  mpool_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd_in),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (q_empty),
    .full  (q_full)
  );

  mpool_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .wr         (wr),
    .cmd_valid  (!q_empty),
    .cmd        (cmd_out),
    .cmd_pop    (pop),
    .idle       (back_idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  a_qfull: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("request queue overflow");
`endif

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT = 500000;

  typedef struct {
    logic [15:0] val;
    logic        pe;
    logic        le;
    logic        re;
  } pool_res_t;

  typedef struct {
    logic [15:0] smp;
    bit          typed;
    logic [15:0] want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [mpool_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mpool_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state
  pool_res_t          res_q[$];
  logic signed [15:0] pool_store[mpool_pkg::MAX_KERNEL*mpool_pkg::MAX_IN_W];
  int                 geo[8];
  int                 row_cnt, col_cnt, plane_cnt, orow_cnt;
  int                 n_err;
  int                 cyc;
  bit                 calm;

  max_pool_2d_stream_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic int clampu(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [15:0] window_peak(input int fy, input int fx, input int k,
                                                     input int iw, input int ih);
    logic signed [15:0] best;
    logic signed [15:0] v;
    int y, x;
    best = '0;
    for (int dy = 0; dy < k; dy++) begin
      for (int dx = 0; dx < k; dx++) begin
        y = fy + dy;
        x = fx + dx;
        v = '0;
        if (y >= 0 && y < ih && x >= 0 && x < iw && x < mpool_pkg::MAX_IN_W)
          v = pool_store[(y % mpool_pkg::MAX_KERNEL) * mpool_pkg::MAX_IN_W + x];
        if ((dy == 0 && dx == 0) || v > best) best = v;
      end
    end
    return best;
  endfunction

  // Work out the pooled results caused by one accepted sample
  task automatic pool_predict(input logic [15:0] smp);
    int iw, ih, ow, oh, k, s, p, ch, n, fy;
    bit row_done, plane_done, last_plane, pe;
    pool_res_t res;
    iw = clampu(geo[mpool_pkg::REG_IN_WIDTH], mpool_pkg::MAX_IN_W);
    ih = clampu(geo[mpool_pkg::REG_IN_HEIGHT], mpool_pkg::MAX_IN_H);
    ow = clampu(geo[mpool_pkg::REG_OUT_WIDTH], mpool_pkg::MAX_OUT_W);
    oh = clampu(geo[mpool_pkg::REG_OUT_HEIGHT], mpool_pkg::MAX_OUT_H);
    k  = clampu(geo[mpool_pkg::REG_KERNEL], mpool_pkg::MAX_KERNEL);
    s  = clampu(geo[mpool_pkg::REG_STRIDE], 7);
    p  = geo[mpool_pkg::REG_PAD];
    ch = clampu(geo[mpool_pkg::REG_CHANNELS], mpool_pkg::MAX_CHAN);
    n  = 0;
    if (col_cnt < mpool_pkg::MAX_IN_W)
      pool_store[(row_cnt % mpool_pkg::MAX_KERNEL) * mpool_pkg::MAX_IN_W + col_cnt] = smp;
    row_done   = col_cnt + 1 >= iw;
    plane_done = row_done && row_cnt + 1 >= ih;
    last_plane = plane_cnt + 1 >= ch;
    if (row_done) begin
      while (orow_cnt < oh && n + ow <= mpool_pkg::RESULT_CAP) begin
        fy = orow_cnt * s - p;
        if (!plane_done && fy + k - 1 > row_cnt) break;
        for (int ox = 0; ox < ow; ox++) begin
          pe = (orow_cnt + 1 >= oh) && (ox + 1 == ow);
          res.val = window_peak(fy, ox * s - p, k, iw, ih);
          res.pe = pe;
          res.le = pe && last_plane;
          res.re = 1'b0;
          res_q.push_back(res);
          n++;
        end
        orow_cnt++;
      end
      // Rows that no longer fit are dropped: mark the plane end early
      if (plane_done && orow_cnt < oh && n > 0) begin
        res_q[$].pe = 1'b1;
        res_q[$].le = last_plane;
      end
    end
    if (n > 0) res_q[$].re = 1'b1;
    if (!row_done) begin
      col_cnt++;
    end else begin
      col_cnt = 0;
      if (!plane_done) begin
        row_cnt++;
      end else begin
        row_cnt = 0;
        orow_cnt = 0;
        plane_cnt = last_plane ? 0 : plane_cnt + 1;
      end
    end
  endtask

  // Send one sample; the gap is drawn up front so valid is never dropped and raised at once
  task automatic send_sample(input logic [15:0] smp, input bit typed, input logic [15:0] want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    pool_predict(smp);
    if (typed) res_q[$].val = want;
  endtask

  // Load all eight geometry registers while the block is idle
  task automatic load_geometry(input int vals[8]);
    int widths[8];
    widths = '{7, 7, 6, 6, 3, 3, 2, 9};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[mpool_pkg::CFG_IDX_W-1:0];
      cfg_wdata <= vals[i][mpool_pkg::CFG_DATA_W-1:0];
      @(posedge clk);
      geo[i] = vals[i] & ((1 << widths[i]) - 1);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    wait (res_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  // Result side: random stalls, compare each result with the oldest expectation
  initial begin
    int stall;
    pool_res_t e;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (res_q.size() == 0) begin
        $display("%0t unexpected result: got val %h user %b last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        n_err++;
      end else begin
        e = res_q.pop_front();
        if (out_tdata !== e.val || out_tuser !== {e.le, e.pe} || out_tlast !== e.re) begin
          $display("%0t mismatch: exp val %h le %b pe %b last %b, got val %h user %b last %b",
                   $time, e.val, e.le, e.pe, e.re, out_tdata, out_tuser, out_tlast);
          n_err++;
        end
      end
    end
  end

  // Calm stretches with no idling on either side
  always begin
    repeat ($urandom_range(50, 400)) @(posedge clk);
    calm = ($urandom_range(0, 3) == 0);
  end

  initial begin
    int geo_tab[6][9];
    int dir_geo[8];
    int cur[8];
    dir_row_t dir_tab[16];
    int n_items;
    logic [15:0] smp;
    // iw, ih, ow, oh, k, s, pad, channels, planes
    geo_tab = '{
      '{8, 8, 4, 4, 2, 2, 0, 1, 1},       // reset geometry
      '{5, 4, 3, 3, 3, 2, 1, 2, 2},       // padded, overlapping windows
      '{0, 0, 32, 32, 1, 0, 0, 511, 3},   // zeros read as one, result cap hit
      '{127, 1, 63, 1, 7, 7, 3, 0, 1},    // saturated widths, windows past the edge
      '{1, 127, 1, 63, 4, 2, 3, 1, 1},    // tall plane, pad not below stride
      '{3, 3, 2, 2, 2, 1, 0, 2, 2}
    };
    dir_geo = '{2, 2, 1, 1, 2, 2, 0, 1};
    // Each group of four is one plane of one window
    dir_tab = '{
      '{16'h8000, 0, 0}, '{16'h8000, 0, 0}, '{16'h8000, 0, 0}, '{16'h8000, 1, 16'h8000},
      '{16'h7fff, 0, 0}, '{16'h8000, 0, 0}, '{16'h0000, 0, 0}, '{16'h0001, 1, 16'h7fff},
      '{16'hffff, 0, 0}, '{16'hfffe, 0, 0}, '{16'h8001, 0, 0}, '{16'hffff, 1, 16'hffff},
      '{16'h0100, 0, 0}, '{16'hfe00, 0, 0}, '{16'h5555, 0, 0}, '{16'haaaa, 0, 0}
    };
    geo = '{8, 8, 4, 4, 2, 2, 0, 1};
    for (int i = 0; i < mpool_pkg::MAX_KERNEL*mpool_pkg::MAX_IN_W; i++) pool_store[i] = '0;
    row_cnt = 0; col_cnt = 0; plane_cnt = 0; orow_cnt = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    load_geometry(dir_geo);
    foreach (dir_tab[i]) send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // Random phases, each a whole number of planes
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) cur[i] = geo_tab[ph][i];
      load_geometry(cur);
      n_items = clampu(geo[mpool_pkg::REG_IN_WIDTH], mpool_pkg::MAX_IN_W)
                * clampu(geo[mpool_pkg::REG_IN_HEIGHT], mpool_pkg::MAX_IN_H)
                * geo_tab[ph][8];
      for (int j = 0; j < n_items; j++) begin
        case ($urandom_range(0, 7))
          0: smp = 16'h8000;
          1: smp = 16'h7fff;
          default: smp = 16'($urandom);
        endcase
        send_sample(smp, 0, '0);
      end
      drain();
    end

    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
